@@ sv/tms_pkg.sv @@
// Package for the Turing machine stepper: codes, state type and helper functions.
package tms_pkg;

   localparam int TMS_TAPE_CELLS = 64;
   localparam int POS_W          = 6;
   localparam int SYM_W          = 2;
   localparam int MSTATE_W       = 4;
   localparam int NSTATE_W       = 3;
   localparam int RATE_W         = 8;
   localparam int PHASE_W        = 3;
   localparam int ACC_W          = 9;
   localparam int RULE_W         = 24;
   localparam int RULE_CNT       = 8;
   localparam int CSR_IDX_W      = 3;

   localparam int STEP_UNITS     = 25;
   localparam logic [MSTATE_W-1:0] HALT_STATE = 4'd8;

   localparam logic [SYM_W-1:0] SYM_ZERO  = 2'd0;
   localparam logic [SYM_W-1:0] SYM_ONE   = 2'd1;
   localparam logic [SYM_W-1:0] SYM_BLANK = 2'd2;

   localparam logic [1:0] MV_RIGHT = 2'd1;
   localparam logic [1:0] MV_LEFT  = 2'd2;

   localparam logic [PHASE_W-1:0] PH_READ  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_WRITE = 3'd3;
   localparam logic [PHASE_W-1:0] PH_MOVE  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_NEXT  = 3'd7;

   typedef enum logic [2:0] {
      ACT_TICK      = 3'd0,
      ACT_START     = 3'd1,
      ACT_CONTINUE  = 3'd2,
      ACT_STOP      = 3'd3,
      ACT_WRITE     = 3'd4,
      ACT_SET_HEAD  = 3'd5,
      ACT_SET_STATE = 3'd6,
      ACT_READ      = 3'd7
   } act_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_STEP,
      ST_STEP_RD,
      ST_FETCH,
      ST_RESP
   } tms_state_type;

   // code 3 is stored as blank
   function automatic logic [SYM_W-1:0] clamp_sym(input logic [SYM_W-1:0] s);
      return (s == 2'd3) ? SYM_BLANK : s;
   endfunction

   // default rule: write the read symbol, stay, keep the state
   function automatic logic [RULE_W-1:0] rule_reset(input logic [2:0] j);
      return 24'h020100 | ({21'd0, j} * 24'h101010);
   endfunction

endpackage

@@ sv/tms_if.sv @@
// Channel interfaces for the Turing machine stepper: request, response and register write.
interface tms_req_if
   import tms_pkg::*;
   ();
   logic                valid;
   logic                ready;
   act_type             action;
   logic [POS_W-1:0]    position;
   logic [SYM_W-1:0]    cell_symbol;
   logic [NSTATE_W-1:0] new_state;
   logic [RATE_W-1:0]   tick_rate;

   modport source (output valid, action, position, cell_symbol, new_state, tick_rate,
                   input ready);
   modport sink   (input valid, action, position, cell_symbol, new_state, tick_rate,
                   output ready);
endinterface

interface tms_rsp_if
   import tms_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [MSTATE_W-1:0] machine_state;
   logic [POS_W-1:0]    head_position;
   logic                active;
   logic [PHASE_W-1:0]  phase;
   logic [SYM_W-1:0]    symbol_out;

   modport source (output valid, machine_state, head_position, active, phase, symbol_out,
                   input ready);
   modport sink   (input valid, machine_state, head_position, active, phase, symbol_out,
                   output ready);
endinterface

interface tms_csr_if
   import tms_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [RULE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/turing_machine_stepper.sv @@
// Turing machine stepper top level: tape memory, rule registers and step sequencer.
//
//  channel | dir | handshake          | payload
//  req     | in  | req.valid/ready    | action, position, cell_symbol, new_state, tick_rate
//  rsp     | out | rsp.valid/ready    | machine_state, head_position, active, phase, symbol_out
//  csr     | in  | csr.valid/ready    | index, data (rule register write)
//
// One request at a time. A control request, or a tick while inactive, passes through
// accept, execute, tape read and response. A tick while active adds the step state,
// which advances one phase per cycle while the accumulator holds a step's units, and
// a tape read state after each read phase.
// After reset the tape is cleared one cell per cycle before the first request is
// taken. A request is taken while a response waits on rsp.
module turing_machine_stepper
   import tms_pkg::*;
   #(
      parameter int TAPE_CELLS = TMS_TAPE_CELLS
   )
   (
      input  logic       clock,
      input  logic       reset,
      tms_req_if.sink    req,
      tms_rsp_if.source  rsp,
      tms_csr_if.sink    csr
   );

   localparam int HEAD_W = (TAPE_CELLS > 2) ? $clog2(TAPE_CELLS) : 1;
   localparam int CMP_W  = ((HEAD_W > POS_W) ? HEAD_W : POS_W) + 1;
   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(TAPE_CELLS - 1);
   localparam logic [HEAD_W-1:0] HEAD_INIT = HEAD_W'(TAPE_CELLS / 2);

   tms_state_type state_ff, state_in;

   logic [RULE_W-1:0]   rule_ff [RULE_CNT];
   logic [SYM_W-1:0]    tape_mem [TAPE_CELLS];

   logic [HEAD_W-1:0]   head_ff, head_in;
   logic [MSTATE_W-1:0] cur_ff, cur_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [SYM_W-1:0]    rsym_ff, rsym_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                run_ff, run_in;
   logic                active_ff, active_in;
   logic [HEAD_W-1:0]   clr_ff, clr_in;

   act_type             act_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [SYM_W-1:0]    csym_ff;
   logic [NSTATE_W-1:0] nst_ff;
   logic [RATE_W-1:0]   rate_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [MSTATE_W-1:0] rsp_mstate_ff;
   logic [POS_W-1:0]    rsp_head_ff;
   logic                rsp_active_ff;
   logic [PHASE_W-1:0]  rsp_phase_ff;
   logic [SYM_W-1:0]    rsp_sym_ff;
   logic                rsp_load;

   logic                mem_wr_en, mem_rd_en;
   logic [HEAD_W-1:0]   mem_wr_addr, mem_rd_addr;
   logic [SYM_W-1:0]    mem_wr_data, rd_data_ff;

   logic                req_fire;
   logic [CMP_W-1:0]    pos_ext;
   logic                in_tape;
   logic [HEAD_W-1:0]   pos_addr;
   logic [7:0]          rule_byte;
   logic                step_go;
   logic                out_free;
   logic                run_next;

   assign req_fire = req.valid && req.ready;
   assign pos_ext  = CMP_W'(pos_ff);
   assign in_tape  = pos_ext < CMP_W'(TAPE_CELLS);
   assign pos_addr = HEAD_W'(pos_ext);
   assign step_go  = (acc_ff >= ACC_W'(STEP_UNITS)) && active_ff;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // rule for the current state and the last symbol read
   always_comb begin
      logic [RULE_W-1:0] rule_word;
      rule_word = rule_ff[cur_ff[2:0]];
      case (clamp_sym(rsym_ff))
         SYM_ZERO: rule_byte = rule_word[7:0];
         SYM_ONE:  rule_byte = rule_word[15:8];
         default:  rule_byte = rule_word[23:16];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clr_ff == HEAD_LAST) state_in = ST_IDLE;
         ST_IDLE:    if (req_fire) state_in = ST_EXEC;
         ST_EXEC:    state_in = (act_ff == ACT_TICK && active_ff) ? ST_STEP : ST_FETCH;
         ST_STEP: begin
            if (!step_go) state_in = ST_FETCH;
            else if (phase_ff == PH_READ) state_in = ST_STEP_RD;
         end
         ST_STEP_RD: state_in = ST_STEP;
         ST_FETCH:   state_in = ST_RESP;
         ST_RESP:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      head_in     = head_ff;
      cur_in      = cur_ff;
      phase_in    = phase_ff;
      rsym_in     = rsym_ff;
      acc_in      = acc_ff;
      run_in      = run_ff;
      active_in   = active_ff;
      clr_in      = clr_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = head_ff;
      mem_wr_data = SYM_ZERO;
      mem_rd_en   = 1'b0;
      mem_rd_addr = head_ff;
      rsp_load    = 1'b0;
      run_next    = run_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
         end
         ST_IDLE: ;
         ST_EXEC: begin
            unique case (act_ff)
               ACT_TICK: if (active_ff) acc_in = acc_ff + ACC_W'(rate_ff);
               ACT_START: begin
                  if (!active_ff) begin
                     run_in    = 1'b1;
                     active_in = 1'b1;
                     cur_in    = '0;
                     acc_in    = '0;
                  end
               end
               ACT_CONTINUE: begin
                  if (!active_ff && cur_ff != HALT_STATE) begin
                     run_in    = 1'b1;
                     active_in = 1'b1;
                     acc_in    = '0;
                  end
               end
               ACT_STOP: run_in = 1'b0;
               ACT_WRITE: begin
                  if (!active_ff && in_tape) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = pos_addr;
                     mem_wr_data = clamp_sym(csym_ff);
                  end
               end
               ACT_SET_HEAD:  if (!active_ff && in_tape) head_in = pos_addr;
               ACT_SET_STATE: if (!active_ff) cur_in = MSTATE_W'(nst_ff);
               ACT_READ: ;
            endcase
         end
         ST_STEP: begin
            if (step_go) begin
               acc_in   = acc_ff - ACC_W'(STEP_UNITS);
               phase_in = phase_ff + 1'b1;
               case (phase_ff)
                  PH_READ: mem_rd_en = 1'b1;
                  PH_WRITE: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = clamp_sym(rule_byte[1:0]);
                  end
                  PH_MOVE: begin
                     if (rule_byte[3:2] == MV_RIGHT && head_ff != HEAD_LAST)
                        head_in = head_ff + 1'b1;
                     else if (rule_byte[3:2] == MV_LEFT && head_ff != '0)
                        head_in = head_ff - 1'b1;
                  end
                  PH_NEXT: begin
                     if (rule_byte[7:4] >= HALT_STATE) begin
                        cur_in   = HALT_STATE;
                        run_next = 1'b0;
                     end else begin
                        cur_in = rule_byte[7:4];
                     end
                     run_in = run_next;
                     if (!run_next) active_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_STEP_RD: rsym_in = rd_data_ff;
         ST_FETCH: begin
            mem_rd_en = 1'b1;
            if (act_ff == ACT_READ && in_tape) mem_rd_addr = pos_addr;
         end
         ST_RESP: rsp_load = out_free;
         default: ;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);
   end

   // tape memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr_en) tape_mem[mem_wr_addr] <= mem_wr_data;
      if (mem_rd_en) rd_data_ff <= tape_mem[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         head_ff      <= HEAD_INIT;
         cur_ff       <= '0;
         phase_ff     <= '0;
         rsym_ff      <= '0;
         acc_ff       <= '0;
         run_ff       <= 1'b0;
         active_ff    <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < RULE_CNT; j++) rule_ff[j] <= rule_reset(3'(j));
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cur_ff       <= cur_in;
         phase_ff     <= phase_in;
         rsym_ff      <= rsym_in;
         acc_ff       <= acc_in;
         run_ff       <= run_in;
         active_ff    <= active_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) rule_ff[csr.index] <= csr.data;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff  <= req.action;
         pos_ff  <= req.position;
         csym_ff <= req.cell_symbol;
         nst_ff  <= req.new_state;
         rate_ff <= req.tick_rate;
      end
      if (rsp_load) begin
         rsp_mstate_ff <= cur_ff;
         rsp_head_ff   <= POS_W'(head_ff);
         rsp_active_ff <= active_ff;
         rsp_phase_ff  <= phase_ff;
         rsp_sym_ff    <= (act_ff == ACT_READ && !in_tape) ? SYM_ZERO : rd_data_ff;
      end
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign csr.ready         = 1'b1;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.machine_state = rsp_mstate_ff;
   assign rsp.head_position = rsp_head_ff;
   assign rsp.active        = rsp_active_ff;
   assign rsp.phase         = rsp_phase_ff;
   assign rsp.symbol_out    = rsp_sym_ff;

endmodule
